// ===== design/udpc_pkg.sv =====
// Shared types, constants and one's complement helpers for the UDP/IPv4
// checksum block. No dependencies.
package udpc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Wide enough for five 16-bit terms plus a byte
    localparam int SUM_W = 19;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ADDRESS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION_ADDRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_NUMBER     = 2'd2;

    localparam logic [7:0]  PROTOCOL_RESET = 8'd17;
    localparam logic [15:0] OFF_LEN_HI     = 16'd4;
    localparam logic [15:0] OFF_LEN_LO     = 16'd5;
    localparam logic [15:0] OFF_CSUM_HI    = 16'd6;
    localparam logic [15:0] OFF_CSUM_LO    = 16'd7;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // One 16-bit word on its way from the byte front end to the summing back end
    typedef struct packed {
        logic [15:0] word;
        logic        last;
        logic [15:0] length;
        logic [15:0] count;
        logic        overflow;
    } word_t;

    // Fold a wide sum into 16 bits with end-around carry; zero only if s is zero
    function automatic logic [15:0] fold_sum(input logic [SUM_W-1:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {14'd0, s[SUM_W-1:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== design/udp_ipv4_checksum.sv =====
// Top level of the UDP/IPv4 checksum block: configuration registers and the
// front end, word queue and back end. Uses udpc_pkg, udpc_front, udpc_queue, udpc_back.
//
// Takes one segment byte per clock with no gaps of its own, header first, and
// last_byte on the final byte. Bytes pair into big-endian words in the front
// end and pass through a four-word queue to the back end, which folds them
// into a one's complement sum with end-around carry. The result (checksum,
// saturating byte count, too_long) passes through a finishing register into
// an output register and waits there while the next segment streams in;
// the next segment may start in the cycle after a last byte. Input stalls
// only when the queue fills behind a held result. The pseudo-header sum is
// rebuilt from the registers through addr_sum_reg, dest_sum_reg and pseudo_reg, so
// write configuration before the first byte that uses it.
module udp_ipv4_checksum
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [udpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    input  logic                                last_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [15:0]                         checksum_value,
    output logic [15:0]                         segment_bytes,
    output logic                                too_long
);

    logic [31:0]      source_address_reg;
    logic [31:0]      destination_address_reg;
    logic [7:0]       protocol_number_reg;

    logic             queue_full;
    logic             push_valid;
    udpc_pkg::word_t  push_item;
    logic             pop;
    logic             pop_valid;
    udpc_pkg::word_t  pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_address_reg      <= '0;
            destination_address_reg <= '0;
            protocol_number_reg     <= udpc_pkg::PROTOCOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                udpc_pkg::REG_SOURCE_ADDRESS:      source_address_reg      <= cfg_data;
                udpc_pkg::REG_DESTINATION_ADDRESS: destination_address_reg <= cfg_data;
                udpc_pkg::REG_PROTOCOL_NUMBER:     protocol_number_reg     <= cfg_data[7:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    udpc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    udpc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    udpc_back u_back
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .pop_valid           (pop_valid),
        .pop_item            (pop_item),
        .pop                 (pop),
        .source_address      (source_address_reg),
        .destination_address (destination_address_reg),
        .protocol_number     (protocol_number_reg),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .checksum_value      (checksum_value),
        .segment_bytes       (segment_bytes),
        .too_long            (too_long)
    );

endmodule

// ===== design/udpc_front.sv =====
// Byte front end: counts bytes, captures the length field, blanks the checksum
// field and pairs bytes into big-endian words. Uses udpc_pkg.
module udpc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              queue_full,
    output logic              push_valid,
    output udpc_pkg::word_t   push_item
);

    logic [15:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  held_reg, held_next;
    logic        phase_reg, phase_next;
    logic        overflow_reg, overflow_next;

    logic        fire;
    logic [7:0]  byte_eff;
    logic [15:0] length_upd;
    logic [15:0] count_upd;
    logic        overflow_upd;
    logic        saturated;

    assign in_ready = !queue_full;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        length_upd = length_reg;
        if (offset_reg == udpc_pkg::OFF_LEN_HI)
        begin
            length_upd[15:8] = data_byte;
        end
        else if (offset_reg == udpc_pkg::OFF_LEN_LO)
        begin
            length_upd[7:0] = data_byte;
        end

        byte_eff = ((offset_reg == udpc_pkg::OFF_CSUM_HI) ||
                    (offset_reg == udpc_pkg::OFF_CSUM_LO)) ? 8'd0 : data_byte;

        saturated    = (offset_reg == udpc_pkg::COUNT_MAX);
        count_upd    = saturated ? offset_reg : offset_reg + 16'd1;
        overflow_upd = overflow_reg || saturated;

        push_item.word     = phase_reg ? {held_reg, byte_eff} : {byte_eff, 8'd0};
        push_item.last     = last_byte;
        push_item.length   = length_upd;
        push_item.count    = count_upd;
        push_item.overflow = overflow_upd;
        push_valid         = fire && (phase_reg || last_byte);

        offset_next   = offset_reg;
        length_next   = length_reg;
        held_next     = held_reg;
        phase_next    = phase_reg;
        overflow_next = overflow_reg;

        if (fire)
        begin
            if (last_byte)
            begin
                // segment done: start the next one clean
                offset_next   = '0;
                length_next   = '0;
                held_next     = '0;
                phase_next    = 1'b0;
                overflow_next = 1'b0;
            end
            else
            begin
                offset_next   = count_upd;
                length_next   = length_upd;
                overflow_next = overflow_upd;
                if (phase_reg)
                begin
                    held_next  = '0;
                    phase_next = 1'b0;
                end
                else
                begin
                    held_next  = byte_eff;
                    phase_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            length_reg   <= '0;
            held_reg     <= '0;
            phase_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            offset_reg   <= offset_next;
            length_reg   <= length_next;
            held_reg     <= held_next;
            phase_reg    <= phase_next;
            overflow_reg <= overflow_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte |=> offset_reg == 16'd0 && !phase_reg && !overflow_reg)
        else $error("segment state not cleared after last item");

endmodule

// ===== design/udpc_queue.sv =====
// Short word queue between the byte front end and the summing back end.
// Uses udpc_pkg for the entry type and depth.
module udpc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  udpc_pkg::word_t   push_item,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output udpc_pkg::word_t   pop_item
);

    udpc_pkg::word_t                 entry_reg [udpc_pkg::QUEUE_DEPTH];
    logic [udpc_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [udpc_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [udpc_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == udpc_pkg::COUNT_W'(udpc_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("word pushed into a full queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count lost a word");

endmodule

// ===== design/udpc_back.sv =====
// Summing back end: one's complement sum of the words, pseudo-header add,
// complement and result register. Uses udpc_pkg.
module udpc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  udpc_pkg::word_t   pop_item,
    output logic              pop,
    input  logic [31:0]       source_address,
    input  logic [31:0]       destination_address,
    input  logic [7:0]        protocol_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       checksum_value,
    output logic [15:0]       segment_bytes,
    output logic              too_long
);

    logic [udpc_pkg::SUM_W-1:0] addr_sum_reg;
    logic [udpc_pkg::SUM_W-1:0] dest_sum_reg;
    logic [15:0]                pseudo_reg;

    logic [15:0] run_reg;
    logic        fin_valid_reg;
    logic [15:0] fin_sum_reg;
    logic [15:0] fin_len_reg;
    logic [15:0] fin_count_reg;
    logic        fin_ovf_reg;
    logic        out_valid_reg;
    logic [15:0] csum_reg;
    logic [15:0] count_reg;
    logic        ovf_reg;

    logic        out_advance;
    logic        fin_advance;
    logic [15:0] word_sum;
    logic [15:0] total;
    logic [15:0] csum;

    assign out_advance = !out_valid_reg || out_ready;
    assign fin_advance = fin_valid_reg && out_advance;
    assign pop         = pop_valid && (!fin_valid_reg || out_advance);
    assign word_sum    = udpc_pkg::oc_add16(run_reg, pop_item.word);

    assign total = udpc_pkg::fold_sum(udpc_pkg::SUM_W'(fin_sum_reg) +
                                      udpc_pkg::SUM_W'(pseudo_reg) +
                                      udpc_pkg::SUM_W'(fin_len_reg));
    // a zero checksum goes out as all ones
    assign csum  = (total == 16'hFFFF) ? 16'hFFFF : ~total;

    assign out_valid      = out_valid_reg;
    assign checksum_value = csum_reg;
    assign segment_bytes  = count_reg;
    assign too_long       = ovf_reg;

    // Pseudo-header constant part, refreshed from the registers every cycle
    always_ff @(posedge clk)
    begin
        addr_sum_reg <= udpc_pkg::SUM_W'(source_address[31:16]) +
                        udpc_pkg::SUM_W'(source_address[15:0]);
        dest_sum_reg <= udpc_pkg::SUM_W'(destination_address[31:16]) +
                        udpc_pkg::SUM_W'(destination_address[15:0]) +
                        udpc_pkg::SUM_W'(protocol_number);
        pseudo_reg   <= udpc_pkg::fold_sum(addr_sum_reg + dest_sum_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_item.last)
        begin
            fin_sum_reg   <= word_sum;
            fin_len_reg   <= pop_item.length;
            fin_count_reg <= pop_item.count;
            fin_ovf_reg   <= pop_item.overflow;
        end
        if (fin_advance)
        begin
            csum_reg  <= csum;
            count_reg <= fin_count_reg;
            ovf_reg   <= fin_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                run_reg <= pop_item.last ? 16'd0 : word_sum;
            end
            if (pop && pop_item.last)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_advance)
            begin
                fin_valid_reg <= 1'b0;
            end
            if (out_advance)
            begin
                out_valid_reg <= fin_valid_reg;
            end
        end
    end

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !out_advance |=> fin_valid_reg && $stable(fin_sum_reg))
        else $error("finishing stage dropped a segment");

    a_last_restarts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_item.last |=> fin_valid_reg && run_reg == 16'd0)
        else $error("running sum not restarted after last word");

endmodule
